// File: rtl/fdn_reverb_three_line_core_assert.svh
// Assertion macros for the three-line reverb core.
// Included by the top level; no other dependencies.
`ifndef FDN_REVERB_THREE_LINE_CORE_ASSERT_SVH
`define FDN_REVERB_THREE_LINE_CORE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define FDNR_ASSERT_IMPLIES(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define FDNR_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FDNR_ASSERT_IMPLIES(lbl, ck, rs, ante, cons)
`define FDNR_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif
`endif

// File: rtl/fdnr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the MAC step program of the three-line reverb.
// No dependencies.
package fdnr_pkg;

  localparam int COEF_W    = 16;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_BITS = 14;
  localparam int HALF_LSB  = 8192;
  localparam int NUM_STEPS = 19;
  localparam int STEP_W    = 5;

  localparam logic [COEF_W-1:0] DRY_GAIN_RESET = 16'h4000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INPUT_GAINS    = 3'd0,
    REG_FEEDBACK_GAINS = 3'd1,
    REG_OUTPUT_GAINS   = 3'd2,
    REG_DRY_GAIN       = 3'd3,
    REG_MIX_ROW_FIRST  = 3'd4,
    REG_MIX_ROW_SECOND = 3'd5,
    REG_MIX_ROW_THIRD  = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  typedef enum logic [2:0] {
    OPA_SAMPLE,
    OPA_Y0,
    OPA_Y1,
    OPA_Y2,
    OPA_M0,
    OPA_M1,
    OPA_M2
  } opa_sel_t;

  typedef enum logic [3:0] {
    DST_NONE,
    DST_X0,
    DST_X1,
    DST_X2,
    DST_M0,
    DST_M1,
    DST_M2,
    DST_OUT,
    DST_FB0,
    DST_FB1,
    DST_FB2
  } dst_t;

  typedef struct packed {
    reg_idx_t    bank;
    logic [1:0]  lane;
  } coef_sel_t;

  typedef struct packed {
    opa_sel_t  opa;
    coef_sel_t coef;
    logic      first;
    logic      last;
    dst_t      dst;
  } step_ctl_t;

  function automatic step_ctl_t mk_step(input opa_sel_t o, input reg_idx_t b,
                                        input logic [1:0] l, input logic f,
                                        input logic la, input dst_t d);
    step_ctl_t c;
    c.opa       = o;
    c.coef.bank = b;
    c.coef.lane = l;
    c.first     = f;
    c.last      = la;
    c.dst       = d;
    return c;
  endfunction

  // MAC program: inputs to lines, three mix rows, wet sum, then feedback gains.
  function automatic step_ctl_t step_decode(input logic [STEP_W-1:0] step);
    step_ctl_t c;
    case (step)
      5'd0:    c = mk_step(OPA_SAMPLE, REG_INPUT_GAINS, 2'd0, 1'b1, 1'b1, DST_X0);
      5'd1:    c = mk_step(OPA_SAMPLE, REG_INPUT_GAINS, 2'd1, 1'b1, 1'b1, DST_X1);
      5'd2:    c = mk_step(OPA_SAMPLE, REG_INPUT_GAINS, 2'd2, 1'b1, 1'b1, DST_X2);
      5'd3:    c = mk_step(OPA_Y0, REG_MIX_ROW_FIRST, 2'd0, 1'b1, 1'b0, DST_NONE);
      5'd4:    c = mk_step(OPA_Y1, REG_MIX_ROW_FIRST, 2'd1, 1'b0, 1'b0, DST_NONE);
      5'd5:    c = mk_step(OPA_Y2, REG_MIX_ROW_FIRST, 2'd2, 1'b0, 1'b1, DST_M0);
      5'd6:    c = mk_step(OPA_Y0, REG_MIX_ROW_SECOND, 2'd0, 1'b1, 1'b0, DST_NONE);
      5'd7:    c = mk_step(OPA_Y1, REG_MIX_ROW_SECOND, 2'd1, 1'b0, 1'b0, DST_NONE);
      5'd8:    c = mk_step(OPA_Y2, REG_MIX_ROW_SECOND, 2'd2, 1'b0, 1'b1, DST_M1);
      5'd9:    c = mk_step(OPA_Y0, REG_MIX_ROW_THIRD, 2'd0, 1'b1, 1'b0, DST_NONE);
      5'd10:   c = mk_step(OPA_Y1, REG_MIX_ROW_THIRD, 2'd1, 1'b0, 1'b0, DST_NONE);
      5'd11:   c = mk_step(OPA_Y2, REG_MIX_ROW_THIRD, 2'd2, 1'b0, 1'b1, DST_M2);
      5'd12:   c = mk_step(OPA_SAMPLE, REG_DRY_GAIN, 2'd0, 1'b1, 1'b0, DST_NONE);
      5'd13:   c = mk_step(OPA_Y0, REG_OUTPUT_GAINS, 2'd0, 1'b0, 1'b0, DST_NONE);
      5'd14:   c = mk_step(OPA_Y1, REG_OUTPUT_GAINS, 2'd1, 1'b0, 1'b0, DST_NONE);
      5'd15:   c = mk_step(OPA_Y2, REG_OUTPUT_GAINS, 2'd2, 1'b0, 1'b1, DST_OUT);
      5'd16:   c = mk_step(OPA_M0, REG_FEEDBACK_GAINS, 2'd0, 1'b1, 1'b1, DST_FB0);
      5'd17:   c = mk_step(OPA_M1, REG_FEEDBACK_GAINS, 2'd1, 1'b1, 1'b1, DST_FB1);
      5'd18:   c = mk_step(OPA_M2, REG_FEEDBACK_GAINS, 2'd2, 1'b1, 1'b1, DST_FB2);
      default: c = mk_step(OPA_SAMPLE, REG_INPUT_GAINS, 2'd0, 1'b0, 1'b0, DST_NONE);
    endcase
    return c;
  endfunction

endpackage

// File: rtl/fdn_reverb_three_line_core.sv
`timescale 1ns / 1ps
// Three-line feedback delay network reverb, top level.
// Depends on fdnr_pkg and fdn_reverb_three_line_core_assert.svh.
`include "fdn_reverb_three_line_core_assert.svh"

// Feedback delay network reverb with three circular delay lines. Each accepted
// sample is scaled by the input gains and added to each line's feedback value,
// the delayed line outputs are mixed by a 3x3 matrix and scaled by per-line
// feedback gains to form the next feedback values, and the wet sum of weighted
// line outputs plus the dry path is returned, saturated to SAMPLE_BITS. All
// coefficients are signed Q2.14 with round-half-up. The delayed line outputs
// are read at a sample's accepting edge itself; the sequencer then runs its
// program, in which a single shared multiply-accumulate unit runs 19 products
// and its pipeline drains, and a done state publishes the result and advances
// the line pointers. The shared MAC sets the sample rate; the input side is
// ready only while the sequencer is idle, and a result still waiting in the
// output register holds the sequencer in its done state and so holds off the
// next sample. There is no clearing pass after reset: each line keeps a wrap
// flag, and until a line has wrapped once its outputs read as zero.
// Configuration is written through a plain write port (enable, register
// index, data); an index beyond the register list is dropped.
module fdn_reverb_three_line_core #(
  parameter int DELAY_ONE   = 1024,
  parameter int DELAY_TWO   = 2048,
  parameter int DELAY_THREE = 4096,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // Input stream; tdata: sample_in (SAMPLE_BITS, signed), zero padded to bytes.
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
  // Output stream; tdata: sample_out (SAMPLE_BITS, signed), zero padded to bytes.
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_axis_tdata,
  // Configuration write port.
  input  logic                                   cfg_wr_en,
  input  logic [fdnr_pkg::CFG_IDX_W-1:0]         cfg_addr,
  input  logic [fdnr_pkg::CFG_W-1:0]             cfg_wdata
);

  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int PROD_W  = SAMPLE_BITS + fdnr_pkg::COEF_W;
  localparam int ACC_W   = PROD_W + 3;
  localparam int RND_W   = ACC_W - fdnr_pkg::FRAC_BITS;
  localparam int SUM_W   = RND_W + 1;
  localparam int P1W     = (DELAY_ONE > 1) ? $clog2(DELAY_ONE) : 1;
  localparam int P2W     = (DELAY_TWO > 1) ? $clog2(DELAY_TWO) : 1;
  localparam int P3W     = (DELAY_THREE > 1) ? $clog2(DELAY_THREE) : 1;
  localparam int SW      = fdnr_pkg::STEP_W;

  localparam logic signed [SUM_W-1:0] SAT_MAX =
    {{(SUM_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sum(
    input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    c = v;
    if (v > SAT_MAX) begin
      c = SAT_MAX;
    end else if (v < SAT_MIN) begin
      c = SAT_MIN;
    end
    return c[SAMPLE_BITS-1:0];
  endfunction

  // Configuration registers.
  logic [fdnr_pkg::CFG_W-1:0]  input_gains;
  logic [fdnr_pkg::CFG_W-1:0]  feedback_gains;
  logic [fdnr_pkg::CFG_W-1:0]  output_gains;
  logic [fdnr_pkg::COEF_W-1:0] dry_gain;
  logic [fdnr_pkg::CFG_W-1:0]  mix_row_first;
  logic [fdnr_pkg::CFG_W-1:0]  mix_row_second;
  logic [fdnr_pkg::CFG_W-1:0]  mix_row_third;

  // Sequencer and datapath state.
  fdnr_pkg::state_t             state;
  logic [SW-1:0]                step;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic signed [SAMPLE_BITS-1:0] fb [3];
  logic signed [SAMPLE_BITS-1:0] mixed [3];
  logic signed [SAMPLE_BITS-1:0] res;
  logic [P1W-1:0]               ptr1;
  logic [P2W-1:0]               ptr2;
  logic [P3W-1:0]               ptr3;
  logic                         wrapped1;
  logic                         wrapped2;
  logic                         wrapped3;

  // Delay line memories and their registered read data.
  logic signed [SAMPLE_BITS-1:0] line_one_mem [DELAY_ONE];
  logic signed [SAMPLE_BITS-1:0] line_two_mem [DELAY_TWO];
  logic signed [SAMPLE_BITS-1:0] line_three_mem [DELAY_THREE];
  logic signed [SAMPLE_BITS-1:0] rd1;
  logic signed [SAMPLE_BITS-1:0] rd2;
  logic signed [SAMPLE_BITS-1:0] rd3;

  // MAC pipeline.
  logic                          issue;
  fdnr_pkg::step_ctl_t           ctl;
  fdnr_pkg::step_ctl_t           ctl1;
  fdnr_pkg::step_ctl_t           ctl2;
  logic                          v1;
  logic                          v2;
  logic signed [SAMPLE_BITS-1:0] opa_val;
  logic [fdnr_pkg::CFG_W-1:0]    bank_val;
  logic signed [fdnr_pkg::COEF_W-1:0] coef_val;
  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       acc_base;
  logic signed [RND_W-1:0]       rnd;
  logic signed [SAMPLE_BITS-1:0] fb_sel;
  logic signed [SUM_W-1:0]       fin_sum;
  logic signed [SAMPLE_BITS-1:0] fin_val;
  logic                          fin;

  logic accept;
  logic out_free;
  logic signed [SAMPLE_BITS-1:0] y1;
  logic signed [SAMPLE_BITS-1:0] y2;
  logic signed [SAMPLE_BITS-1:0] y3;

  assign s_axis_tready = (state == fdnr_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Until a line wraps once, the slot under its pointer has never been written, so its output is forced to zero.
  assign y1 = wrapped1 ? rd1 : '0;
  assign y2 = wrapped2 ? rd2 : '0;
  assign y3 = wrapped3 ? rd3 : '0;

  // Configuration writes; drop indexes beyond the list.
  always_ff @(posedge clk) begin
    if (rst) begin
      input_gains    <= '0;
      feedback_gains <= '0;
      output_gains   <= '0;
      dry_gain       <= fdnr_pkg::DRY_GAIN_RESET;
      mix_row_first  <= '0;
      mix_row_second <= '0;
      mix_row_third  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        fdnr_pkg::REG_INPUT_GAINS:    input_gains    <= cfg_wdata;
        fdnr_pkg::REG_FEEDBACK_GAINS: feedback_gains <= cfg_wdata;
        fdnr_pkg::REG_OUTPUT_GAINS:   output_gains   <= cfg_wdata;
        fdnr_pkg::REG_DRY_GAIN:       dry_gain       <= cfg_wdata[fdnr_pkg::COEF_W-1:0];
        fdnr_pkg::REG_MIX_ROW_FIRST:  mix_row_first  <= cfg_wdata;
        fdnr_pkg::REG_MIX_ROW_SECOND: mix_row_second <= cfg_wdata;
        fdnr_pkg::REG_MIX_ROW_THIRD:  mix_row_third  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Issue stage: decode the current step and pick the multiplier operands.
  assign issue = (state == fdnr_pkg::ST_RUN) && (step < SW'(fdnr_pkg::NUM_STEPS));
  assign ctl   = fdnr_pkg::step_decode(step);

  always_comb begin
    case (ctl.opa)
      fdnr_pkg::OPA_SAMPLE: opa_val = sample;
      fdnr_pkg::OPA_Y0:     opa_val = y1;
      fdnr_pkg::OPA_Y1:     opa_val = y2;
      fdnr_pkg::OPA_Y2:     opa_val = y3;
      fdnr_pkg::OPA_M0:     opa_val = mixed[0];
      fdnr_pkg::OPA_M1:     opa_val = mixed[1];
      fdnr_pkg::OPA_M2:     opa_val = mixed[2];
      default:              opa_val = '0;
    endcase
  end

  always_comb begin
    case (ctl.coef.bank)
      fdnr_pkg::REG_INPUT_GAINS:    bank_val = input_gains;
      fdnr_pkg::REG_FEEDBACK_GAINS: bank_val = feedback_gains;
      fdnr_pkg::REG_OUTPUT_GAINS:   bank_val = output_gains;
      fdnr_pkg::REG_DRY_GAIN:       bank_val = fdnr_pkg::CFG_W'(dry_gain);
      fdnr_pkg::REG_MIX_ROW_FIRST:  bank_val = mix_row_first;
      fdnr_pkg::REG_MIX_ROW_SECOND: bank_val = mix_row_second;
      fdnr_pkg::REG_MIX_ROW_THIRD:  bank_val = mix_row_third;
      default:                      bank_val = '0;
    endcase
  end

  always_comb begin
    case (ctl.coef.lane)
      2'd0:    coef_val = bank_val[15:0];
      2'd1:    coef_val = bank_val[31:16];
      2'd2:    coef_val = bank_val[47:32];
      default: coef_val = '0;
    endcase
  end

  // Accumulate stage: a new sum starts from the rounding bias, so the
  // round-half-up step becomes a plain arithmetic shift at the end.
  assign acc_base = ctl1.first ? ACC_W'(fdnr_pkg::HALF_LSB) : acc;

  always_ff @(posedge clk) begin
    prod <= opa_val * coef_val;
    ctl1 <= ctl;
    if (v1) begin
      acc <= acc_base + ACC_W'(prod);
    end
    ctl2 <= ctl1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
    end
  end

  // Finish stage: round, add the old feedback value for line inputs, saturate.
  assign rnd = RND_W'(acc >>> fdnr_pkg::FRAC_BITS);
  assign fin = v2 && ctl2.last;

  always_comb begin
    case (ctl2.dst)
      fdnr_pkg::DST_X0: fb_sel = fb[0];
      fdnr_pkg::DST_X1: fb_sel = fb[1];
      fdnr_pkg::DST_X2: fb_sel = fb[2];
      default:          fb_sel = '0;
    endcase
  end

  assign fin_sum = SUM_W'(fb_sel) + SUM_W'(rnd);
  assign fin_val = sat_sum(fin_sum);

  // Hold mix rows and the wet result; feedback values are state and reset.
  always_ff @(posedge clk) begin
    if (fin) begin
      case (ctl2.dst)
        fdnr_pkg::DST_M0:  mixed[0] <= fin_val;
        fdnr_pkg::DST_M1:  mixed[1] <= fin_val;
        fdnr_pkg::DST_M2:  mixed[2] <= fin_val;
        fdnr_pkg::DST_OUT: res      <= fin_val;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fb[0] <= '0;
      fb[1] <= '0;
      fb[2] <= '0;
    end else if (fin) begin
      case (ctl2.dst)
        fdnr_pkg::DST_FB0: fb[0] <= fin_val;
        fdnr_pkg::DST_FB1: fb[1] <= fin_val;
        fdnr_pkg::DST_FB2: fb[2] <= fin_val;
        default: ;
      endcase
    end
  end

  // Delay lines: read the delayed sample on acceptance, write the new input later.
  always_ff @(posedge clk) begin
    if (fin && (ctl2.dst == fdnr_pkg::DST_X0)) begin
      line_one_mem[ptr1] <= fin_val;
    end
    if (accept) begin
      rd1 <= line_one_mem[ptr1];
    end
  end

  always_ff @(posedge clk) begin
    if (fin && (ctl2.dst == fdnr_pkg::DST_X1)) begin
      line_two_mem[ptr2] <= fin_val;
    end
    if (accept) begin
      rd2 <= line_two_mem[ptr2];
    end
  end

  always_ff @(posedge clk) begin
    if (fin && (ctl2.dst == fdnr_pkg::DST_X2)) begin
      line_three_mem[ptr3] <= fin_val;
    end
    if (accept) begin
      rd3 <= line_three_mem[ptr3];
    end
  end

  // Input sample register.
  always_ff @(posedge clk) begin
    if (accept) begin
      sample <= s_axis_tdata[SAMPLE_BITS-1:0];
    end
  end

  // Sequencer: idle, run the MAC program plus drain, then publish the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= fdnr_pkg::ST_IDLE;
      step          <= '0;
      ptr1          <= '0;
      ptr2          <= '0;
      ptr3          <= '0;
      wrapped1      <= 1'b0;
      wrapped2      <= 1'b0;
      wrapped3      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // Drop tvalid once taken, unless a new result replaces it in this cycle.
      if (m_axis_tvalid && m_axis_tready && (state != fdnr_pkg::ST_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        fdnr_pkg::ST_IDLE: begin
          if (accept) begin
            state <= fdnr_pkg::ST_RUN;
            step  <= '0;
          end
        end
        fdnr_pkg::ST_RUN: begin
          step <= step + 1'b1;
          if (step == SW'(fdnr_pkg::NUM_STEPS + 1)) begin
            state <= fdnr_pkg::ST_DONE;
          end
        end
        fdnr_pkg::ST_DONE: begin
          // Wait for the output register to free up, then advance all lines.
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            state         <= fdnr_pkg::ST_IDLE;
            if (ptr1 == P1W'(DELAY_ONE - 1)) begin
              ptr1     <= '0;
              wrapped1 <= 1'b1;
            end else begin
              ptr1 <= ptr1 + 1'b1;
            end
            if (ptr2 == P2W'(DELAY_TWO - 1)) begin
              ptr2     <= '0;
              wrapped2 <= 1'b1;
            end else begin
              ptr2 <= ptr2 + 1'b1;
            end
            if (ptr3 == P3W'(DELAY_THREE - 1)) begin
              ptr3     <= '0;
              wrapped3 <= 1'b1;
            end else begin
              ptr3 <= ptr3 + 1'b1;
            end
          end
        end
        default: state <= fdnr_pkg::ST_IDLE;
      endcase
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if ((state == fdnr_pkg::ST_DONE) && out_free) begin
      m_axis_tdata <= TDATA_W'($unsigned(res));
    end
  end

  // Assertions.
  `FDNR_ASSERT_NEXT(a_accept_starts_program, clk, rst, accept, (state == fdnr_pkg::ST_RUN) && (step == '0))
  `FDNR_ASSERT_IMPLIES(a_finish_only_in_run, clk, rst, v2, state == fdnr_pkg::ST_RUN)
  `FDNR_ASSERT_NEXT(a_done_publishes, clk, rst, (state == fdnr_pkg::ST_DONE) && out_free, m_axis_tvalid && (state == fdnr_pkg::ST_IDLE))

endmodule
